[sv/pst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the pulse rate and stability detector.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Field widths of the stream beats and of the configuration registers.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned BPM_W    = 8;
  localparam int unsigned STAB_W   = 16;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // Register reset values.
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 12'd550;
  localparam logic [CFG_W-1:0] MARGIN_RST    = 12'd50;
  localparam logic [CFG_W-1:0] MIN_IVL_RST   = 12'd300;
  localparam logic [CFG_W-1:0] MAX_IVL_RST   = 12'd2000;

  // Arithmetic constants.
  localparam int unsigned BPM_DIVIDEND = 60000;
  localparam int unsigned BPM_MAX      = 255;
  localparam int unsigned STAB_SCALE   = 1280;
  localparam int unsigned STAB_SCALE_W = 11;
  localparam int unsigned STAB_ONE     = 32768;
  localparam logic [STAB_W-1:0] STAB_RST = 16'd16384;

  // Register map, index = paddr[3:2].
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MARGIN    = 2'd1,
    REG_MIN_IVL   = 2'd2,
    REG_MAX_IVL   = 2'd3
  } pst_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_BPM,
    ST_SWEEP,
    ST_MUL,
    ST_ROOT_START,
    ST_ROOT,
    ST_DIV_STAB,
    ST_FINISH
  } pst_state_e;

endpackage

[sv/pst_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_stream_if
// Valid/ready channels for sensor samples and detector results.
// ----------------------------------------------------------------------------
interface pst_in_if;
  import pst_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   time_ms;

  modport source (output valid, output sample, output time_ms, input ready);
  modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface pst_out_if;
  import pst_pkg::*;

  logic              valid;
  logic              ready;
  logic              beat_seen;
  logic              interval_valid;
  logic [BPM_W-1:0]  bpm;
  logic [STAB_W-1:0] stability;
  logic              stability_ready;

  modport source (output valid, output beat_seen, output interval_valid, output bpm,
                  output stability, output stability_ready, input ready);
  modport sink   (input valid, input beat_seen, input interval_valid, input bpm,
                  input stability, input stability_ready, output ready);
endinterface

[sv/pst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pst_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pst_div #(
  parameter int unsigned DVD_W = 35,
  parameter int unsigned DVS_W = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVD_W-1:0] dq_q, dq_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  // One shift-subtract step: the dividend shifts out the top while the
  // quotient shifts in at the bottom.
  assign trial = {rem_q, dq_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DVS_W-1:0];
        dq_d  = {dq_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        dq_d  = {dq_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

[sv/pst_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_sqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pst_sqrt #(
  parameter int unsigned RAD_W = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);

  localparam int unsigned R_W   = RAD_W / 2;
  localparam int unsigned CNT_W = $clog2(R_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [R_W+1:0]   rem_q, rem_d;
  logic [R_W-1:0]   root_q, root_d;
  logic [R_W+1:0]   rem_sh;
  logic [R_W+1:0]   trial;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_sh = {rem_q[R_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      cnt_d  = CNT_W'(R_W);
      busy_d = 1'b1;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[R_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[R_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[sv/pulse_rate_and_stability.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_rate_and_stability
// Threshold beat detector with rate and beat-interval regularity figures.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sensor sample and its millisecond timestamp per beat;
//   out_ch returns exactly one result beat for every input beat, in order.
//   Write registers over the APB port only while the block is idle (unenforced).
// Processing:
//   A sample that does not start a beat with an in-window interval is
//   answered directly; its result is in the output register the cycle after.
//   A valid beat runs one divide for the rate. Once the history is full it
//   also sweeps the interval RAM, forms the variance term, takes a square
//   root and runs a second divide on the shared divider. No new sample is
//   taken until the run has finished.
// Reset:
//   Registers take their reset values, the rate reads 0 and the stability
//   0.5. The interval RAM is not cleared: it is only summed once every entry
//   has been written, so no clearing pass is needed.
// Backpressure:
//   A finished result waits in the output register; in_ch.ready stays low
//   during a run and while a result waits, save in the cycle it leaves.
// ----------------------------------------------------------------------------
module pulse_rate_and_stability #(
  parameter int unsigned HISTORY_LEN = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pst_pkg::APB_AW-1:0]  paddr,
  input  logic [pst_pkg::APB_DW-1:0]  pwdata,
  output logic [pst_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // Streams.
  pst_in_if.sink                      in_ch,
  pst_out_if.source                   out_ch
);

  import pst_pkg::*;

  // Widths derived from the history depth.
  localparam int unsigned IDX_W  = $clog2(HISTORY_LEN);
  localparam int unsigned CNT_W  = $clog2(HISTORY_LEN + 1);
  localparam int unsigned IVL_W  = CFG_W;
  localparam int unsigned SUM_W  = IVL_W + $clog2(HISTORY_LEN);
  localparam int unsigned Q_W    = 2 * IVL_W + $clog2(HISTORY_LEN);
  localparam int unsigned NQ_W   = Q_W + $clog2(HISTORY_LEN + 1);
  localparam int unsigned RAD_W  = NQ_W + 16 + (NQ_W % 2);
  localparam int unsigned R_W    = RAD_W / 2;
  localparam int unsigned DVD_W  = R_W + STAB_SCALE_W;

  pst_state_e state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0]  thr_q, thr_d;
  logic [CFG_W-1:0]  margin_q, margin_d;
  logic [CFG_W-1:0]  min_ivl_q, min_ivl_d;
  logic [CFG_W-1:0]  max_ivl_q, max_ivl_d;

  // Detector state.
  logic              above_q, above_d;
  logic [TIME_W-1:0] last_ms_q, last_ms_d;
  logic [BPM_W-1:0]  rate_q, rate_d;
  logic [STAB_W-1:0] stab_q, stab_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;

  // Sweep and arithmetic working registers.
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rdv_q, rdv_d;
  logic [IVL_W-1:0]  ivl_q, ivl_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [Q_W-1:0]    sq_q, sq_d;
  logic [NQ_W-1:0]   nq_q, nq_d;
  logic [NQ_W-1:0]   ss_q, ss_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              out_beat_q, out_beat_d;
  logic              out_ivalid_q, out_ivalid_d;
  logic [BPM_W-1:0]  out_bpm_q, out_bpm_d;
  logic [STAB_W-1:0] out_stab_q, out_stab_d;
  logic              out_srdy_q, out_srdy_d;

  // Unit hookups.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IVL_W-1:0]  ram_rdata;
  logic              div_start, div_busy, div_done;
  logic [DVD_W-1:0]  div_dividend, div_quot;
  logic [SUM_W-1:0]  div_divisor;
  logic              sqrt_start, sqrt_busy, sqrt_done;
  logic [RAD_W-1:0]  sqrt_rad;
  logic [R_W-1:0]    sqrt_root;

  // Per-sample decisions.
  logic              in_acc, out_free, cfg_wr;
  logic              beat, rearm, ivl_ok, hist_full;
  logic [TIME_W-1:0] ivl32;
  logic [2*IVL_W-1:0] xx;
  logic [NQ_W-1:0]   var_diff;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // Beat detection; the re-arm level test is done as sample + margin < thr.
  assign beat  = (in_ch.sample > thr_q) && !above_q;
  assign rearm = ({1'b0, in_ch.sample} + {1'b0, margin_q}) < {1'b0, thr_q};
  assign ivl32 = in_ch.time_ms - last_ms_q;
  assign ivl_ok = (ivl32 > TIME_W'(min_ivl_q)) && (ivl32 < TIME_W'(max_ivl_q));
  assign hist_full = (fill_q == CNT_W'(HISTORY_LEN));

  // Square term of the sweep and the variance term N*Q - S*S.
  assign xx       = (2*IVL_W)'(ram_rdata) * (2*IVL_W)'(ram_rdata);
  assign var_diff = (nq_q > ss_q) ? (nq_q - ss_q) : '0;

  // Register read-back.
  always_comb begin
    unique case (pst_reg_e'(paddr[3:2]))
      REG_THRESHOLD: prdata = APB_DW'(thr_q);
      REG_MARGIN:    prdata = APB_DW'(margin_q);
      REG_MIN_IVL:   prdata = APB_DW'(min_ivl_q);
      REG_MAX_IVL:   prdata = APB_DW'(max_ivl_q);
    endcase
  end

  // Register writes.
  always_comb begin
    thr_d     = thr_q;
    margin_d  = margin_q;
    min_ivl_d = min_ivl_q;
    max_ivl_d = max_ivl_q;
    if (cfg_wr) begin
      unique case (pst_reg_e'(paddr[3:2]))
        REG_THRESHOLD: thr_d     = pwdata[CFG_W-1:0];
        REG_MARGIN:    margin_d  = pwdata[CFG_W-1:0];
        REG_MIN_IVL:   min_ivl_d = pwdata[CFG_W-1:0];
        REG_MAX_IVL:   max_ivl_d = pwdata[CFG_W-1:0];
      endcase
    end
  end

  // Sequencer: next state, unit controls and datapath updates.
  always_comb begin
    state_d      = state_q;
    above_d      = above_q;
    last_ms_d    = last_ms_q;
    rate_d       = rate_q;
    stab_d       = stab_q;
    ptr_d        = ptr_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    rdv_d        = 1'b0;
    ivl_d        = ivl_q;
    sum_d        = sum_q;
    sq_d         = sq_q;
    nq_d         = nq_q;
    ss_d         = ss_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_beat_d   = out_beat_q;
    out_ivalid_d = out_ivalid_q;
    out_bpm_d    = out_bpm_q;
    out_stab_d   = out_stab_q;
    out_srdy_d   = out_srdy_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cnt_q[IDX_W-1:0];
    div_start    = 1'b0;
    div_dividend = DVD_W'(BPM_DIVIDEND);
    div_divisor  = SUM_W'(ivl32[IVL_W-1:0]);
    sqrt_start   = 1'b0;
    sqrt_rad     = RAD_W'({var_diff, 16'h0000});

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (beat) begin
            above_d   = 1'b1;
            last_ms_d = in_ch.time_ms;
          end else if (rearm) begin
            above_d = 1'b0;
          end
          if (beat && ivl_ok) begin
            // Valid beat: the rate divide starts right away.
            ivl_d     = ivl32[IVL_W-1:0];
            div_start = 1'b1;
            state_d   = ST_DIV_BPM;
          end else begin
            out_valid_d  = 1'b1;
            out_beat_d   = beat;
            out_ivalid_d = 1'b0;
            out_bpm_d    = rate_q;
            out_stab_d   = stab_q;
            out_srdy_d   = hist_full;
          end
        end
      end

      ST_DIV_BPM: begin
        if (div_done) begin
          rate_d = (div_quot > DVD_W'(BPM_MAX)) ? BPM_W'(BPM_MAX) : div_quot[BPM_W-1:0];
          ram_we = 1'b1;
          ptr_d  = (ptr_q == IDX_W'(HISTORY_LEN - 1)) ? '0 : ptr_q + IDX_W'(1);
          if (!hist_full) begin
            fill_d = fill_q + CNT_W'(1);
          end
          if (fill_q >= CNT_W'(HISTORY_LEN - 1)) begin
            cnt_d   = '0;
            sum_d   = '0;
            sq_d    = '0;
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_SWEEP: begin
        // Issue one RAM read per cycle; accumulate each read word in the cycle after.
        if (cnt_q != CNT_W'(HISTORY_LEN)) begin
          ram_re = 1'b1;
          rdv_d  = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        if (rdv_q) begin
          sum_d = sum_q + SUM_W'(ram_rdata);
          sq_d  = sq_q + Q_W'(xx);
          if (cnt_q == CNT_W'(HISTORY_LEN)) begin
            state_d = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        nq_d    = NQ_W'(sq_q) * NQ_W'(HISTORY_LEN);
        ss_d    = NQ_W'(sum_q) * NQ_W'(sum_q);
        state_d = ST_ROOT_START;
      end

      ST_ROOT_START: begin
        sqrt_start = 1'b1;
        state_d    = ST_ROOT;
      end

      ST_ROOT: begin
        if (sqrt_done) begin
          div_start    = 1'b1;
          div_dividend = DVD_W'(sqrt_root) * DVD_W'(STAB_SCALE);
          div_divisor  = (sum_q == '0) ? SUM_W'(1) : sum_q;
          state_d      = ST_DIV_STAB;
        end
      end

      ST_DIV_STAB: begin
        if (div_done) begin
          stab_d  = (div_quot >= DVD_W'(STAB_ONE)) ? '0 :
                    STAB_W'(STAB_ONE) - div_quot[STAB_W-1:0];
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_beat_d   = 1'b1;
          out_ivalid_d = 1'b1;
          out_bpm_d    = rate_q;
          out_stab_d   = stab_q;
          out_srdy_d   = hist_full;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESHOLD_RST;
      margin_q    <= MARGIN_RST;
      min_ivl_q   <= MIN_IVL_RST;
      max_ivl_q   <= MAX_IVL_RST;
      above_q     <= 1'b0;
      last_ms_q   <= '0;
      rate_q      <= '0;
      stab_q      <= STAB_RST;
      ptr_q       <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      margin_q    <= margin_d;
      min_ivl_q   <= min_ivl_d;
      max_ivl_q   <= max_ivl_d;
      above_q     <= above_d;
      last_ms_q   <= last_ms_d;
      rate_q      <= rate_d;
      stab_q      <= stab_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ivl_q        <= ivl_d;
    sum_q        <= sum_d;
    sq_q         <= sq_d;
    nq_q         <= nq_d;
    ss_q         <= ss_d;
    out_beat_q   <= out_beat_d;
    out_ivalid_q <= out_ivalid_d;
    out_bpm_q    <= out_bpm_d;
    out_stab_q   <= out_stab_d;
    out_srdy_q   <= out_srdy_d;
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.beat_seen       = out_beat_q;
  assign out_ch.interval_valid  = out_ivalid_q;
  assign out_ch.bpm             = out_bpm_q;
  assign out_ch.stability       = out_stab_q;
  assign out_ch.stability_ready = out_srdy_q;

  // Interval history.
  pst_ram #(
    .WIDTH (IVL_W),
    .DEPTH (HISTORY_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (ivl_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Divider shared by the rate and the stability ratio.
  pst_div #(
    .DVD_W (DVD_W),
    .DVS_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Square root of the scaled variance term.
  pst_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // The divider and the square-root unit never run together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(div_busy && sqrt_busy))
    else $error("divider and square root busy at the same time");

  // Every accepted sample either produces a result at once or starts a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_ch.valid || state_q != ST_IDLE))
    else $error("accepted sample produced neither a result nor a run");

  // Each history write advances the ring pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (ptr_q != $past(ptr_q)))
    else $error("ring pointer did not advance after a history write");

  // The stability figure stays within Q1.15 range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stab_q <= STAB_W'(STAB_ONE))
    else $error("stability figure out of range");

endmodule
